[src/sfo_pkg.sv]
package sfo_pkg;

	// widths of the oscillator data path
	localparam int DATA_W    = 32;
	localparam int FRAC_BITS = 24;
	localparam int K_W       = DATA_W - 1;
	localparam int DT_W      = 24;
	localparam int CD_W      = 26;
	localparam int MUL_W     = CD_W + DATA_W;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int SCALE_W   = CD_W + DT_W + 1;

	// step size after reset, about 0.01
	localparam logic [DT_W-1:0] DT_RESET = DT_W'(167772);

	// yoshida weights, signed Q2.24
	localparam logic signed [CD_W-1:0] COEF_C14 = CD_W'(11334747);
	localparam logic signed [CD_W-1:0] COEF_C23 = -CD_W'(2946139);
	localparam logic signed [CD_W-1:0] COEF_D13 = CD_W'(22669495);
	localparam logic signed [CD_W-1:0] COEF_D2  = -CD_W'(28561774);

	localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef struct packed {
		logic signed [DATA_W-1:0] position;
		logic signed [DATA_W-1:0] momentum;
		logic [K_W-1:0]           stiffness;
	} item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] position_next;
		logic signed [DATA_W-1:0] momentum_next;
		logic                     overflow;
	} result_t;

	// oscillator state as it moves down the pipeline
	typedef struct packed {
		logic signed [DATA_W-1:0] q;
		logic signed [DATA_W-1:0] p;
		logic signed [DATA_W-1:0] g14;
		logic signed [DATA_W-1:0] g23;
		logic                     ov;
	} state_t;

	// weights already scaled by the step size
	typedef struct packed {
		logic signed [CD_W-1:0] c14;
		logic signed [CD_W-1:0] c23;
		logic signed [CD_W-1:0] d13;
		logic signed [CD_W-1:0] d2;
	} coef_t;

	// round(coef * dt / 2^24), ties away from zero; never leaves CD_W
	function automatic logic signed [CD_W-1:0] scale_coef(input logic signed [CD_W-1:0] coef,
			input logic [DT_W-1:0] dt);
		logic signed [SCALE_W-1:0] prod;
		logic signed [SCALE_W-1:0] rnd;
		prod = SCALE_W'(coef) * $signed({1'b0, dt});
		rnd  = prod + (SCALE_W'(1) <<< (FRAC_BITS - 1)) - SCALE_W'(prod[SCALE_W-1]);
		rnd  = rnd >>> FRAC_BITS;
		return rnd[CD_W-1:0];
	endfunction

	// round a full product by 2^24 (ties away from zero), saturate; returns {ov, value}
	// weights and data share the same fraction width
	function automatic logic [DATA_W:0] rnd_sat(input logic signed [PROD_W-1:0] x);
		logic signed [PROD_W-1:0] rnd;
		logic [PROD_W-DATA_W:0]   top;
		rnd = x + (PROD_W'(1) <<< (FRAC_BITS - 1)) - PROD_W'(x[PROD_W-1]);
		rnd = rnd >>> FRAC_BITS;
		top = rnd[PROD_W-1:DATA_W-1];
		if (&top || ~|top) begin
			return {1'b0, rnd[DATA_W-1:0]};
		end else if (rnd[PROD_W-1]) begin
			return {1'b1, SAT_MIN};
		end else begin
			return {1'b1, SAT_MAX};
		end
	endfunction

	// saturating add or subtract; returns {ov, value}
	function automatic logic [DATA_W:0] sat_sum(input logic signed [DATA_W-1:0] a,
			input logic signed [DATA_W-1:0] b, input logic sub);
		logic signed [DATA_W:0] s;
		if (sub) begin
			s = (DATA_W+1)'(a) - (DATA_W+1)'(b);
		end else begin
			s = (DATA_W+1)'(a) + (DATA_W+1)'(b);
		end
		if (s[DATA_W] == s[DATA_W-1]) begin
			return {1'b0, s[DATA_W-1:0]};
		end else if (s[DATA_W]) begin
			return {1'b1, SAT_MIN};
		end else begin
			return {1'b1, SAT_MAX};
		end
	endfunction

endpackage

[src/symplectic_fourth_order_oscillator_step.sv]
// channel   direction  handshake                    payload
// item      in         item_valid / item_stall      item_t: position, momentum, stiffness
// result    out        result_valid / result_stall  result_t: position_next, momentum_next,
//                                                   overflow
// cfg       in         cfg_valid / cfg_ready        cfg_time_step (dt, Q0.24)
//
// one item per clock while result_stall is low; the gain unit and each of the four kicks and
// three drifts hold one multiplier stage and one round/saturate/add stage
// every stage holds its own valid bit; bubbles close up under a result stall
// result stall reaches item_stall through the stage ready chain
// arst_n clears all valid bits and loads the weights scaled for the reset step size
module symplectic_fourth_order_oscillator_step import sfo_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  item_t           item,
	output logic            result_valid,
	input  logic            result_stall,
	output result_t         result,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [DT_W-1:0] cfg_time_step
);

	coef_t  coef;
	state_t st [8];
	logic   vld [8];
	logic   rdy [8];
	logic   gain_ready;

	// step size and scaled weights
	sfo_cfg u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_time_step (cfg_time_step),
		.coef          (coef)
	);

	// kick gains from stiffness
	sfo_gain u_gain (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item_valid),
		.in_ready  (gain_ready),
		.item      (item),
		.coef      (coef),
		.out_valid (vld[0]),
		.out_ready (rdy[0]),
		.out_st    (st[0])
	);

	assign item_stall = !gain_ready;

	// kick, drift, kick, drift, kick, drift, kick
	sfo_kick u_kick1 (
		.clk (clk), .arst_n (arst_n),
		.in_valid (vld[0]), .in_ready (rdy[0]), .in_st (st[0]), .gain (st[0].g14),
		.out_valid (vld[1]), .out_ready (rdy[1]), .out_st (st[1])
	);

	sfo_drift u_drift1 (
		.clk (clk), .arst_n (arst_n),
		.in_valid (vld[1]), .in_ready (rdy[1]), .in_st (st[1]), .cd (coef.d13),
		.out_valid (vld[2]), .out_ready (rdy[2]), .out_st (st[2])
	);

	sfo_kick u_kick2 (
		.clk (clk), .arst_n (arst_n),
		.in_valid (vld[2]), .in_ready (rdy[2]), .in_st (st[2]), .gain (st[2].g23),
		.out_valid (vld[3]), .out_ready (rdy[3]), .out_st (st[3])
	);

	sfo_drift u_drift2 (
		.clk (clk), .arst_n (arst_n),
		.in_valid (vld[3]), .in_ready (rdy[3]), .in_st (st[3]), .cd (coef.d2),
		.out_valid (vld[4]), .out_ready (rdy[4]), .out_st (st[4])
	);

	sfo_kick u_kick3 (
		.clk (clk), .arst_n (arst_n),
		.in_valid (vld[4]), .in_ready (rdy[4]), .in_st (st[4]), .gain (st[4].g23),
		.out_valid (vld[5]), .out_ready (rdy[5]), .out_st (st[5])
	);

	sfo_drift u_drift3 (
		.clk (clk), .arst_n (arst_n),
		.in_valid (vld[5]), .in_ready (rdy[5]), .in_st (st[5]), .cd (coef.d13),
		.out_valid (vld[6]), .out_ready (rdy[6]), .out_st (st[6])
	);

	sfo_kick u_kick4 (
		.clk (clk), .arst_n (arst_n),
		.in_valid (vld[6]), .in_ready (rdy[6]), .in_st (st[6]), .gain (st[6].g14),
		.out_valid (vld[7]), .out_ready (rdy[7]), .out_st (st[7])
	);

	// last kick stage is the output register
	assign rdy[7]               = !result_stall;
	assign result_valid         = vld[7];
	assign result.position_next = st[7].q;
	assign result.momentum_next = st[7].p;
	assign result.overflow      = st[7].ov;

endmodule

[src/sfo_cfg.sv]
module sfo_cfg import sfo_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [DT_W-1:0] cfg_time_step,
	output coef_t           coef
);

	coef_t coef_q;

	// writes are always taken
	assign cfg_ready = 1'b1;

	// scale all four weights by the new step size on a write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.c14 <= scale_coef(COEF_C14, DT_RESET);
			coef_q.c23 <= scale_coef(COEF_C23, DT_RESET);
			coef_q.d13 <= scale_coef(COEF_D13, DT_RESET);
			coef_q.d2  <= scale_coef(COEF_D2, DT_RESET);
		end else if (cfg_valid && cfg_ready) begin
			coef_q.c14 <= scale_coef(COEF_C14, cfg_time_step);
			coef_q.c23 <= scale_coef(COEF_C23, cfg_time_step);
			coef_q.d13 <= scale_coef(COEF_D13, cfg_time_step);
			coef_q.d2  <= scale_coef(COEF_D2, cfg_time_step);
		end
	end

	assign coef = coef_q;

endmodule

[src/sfo_gain.sv]
module sfo_gain import sfo_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  item_t  item,
	input  coef_t  coef,
	output logic   out_valid,
	input  logic   out_ready,
	output state_t out_st
);

	logic                    valid_s1;
	item_t                   item_s1;
	logic signed [MUL_W-1:0] prod14_s1;
	logic signed [MUL_W-1:0] prod23_s1;
	logic                    valid_s2;
	state_t                  st_s2;
	logic                    ready_s1;
	logic                    ready_s2;
	logic [DATA_W:0]         r14;
	logic [DATA_W:0]         r23;

	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	// stage 1: both kick weights times stiffness
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			item_s1   <= item;
			prod14_s1 <= coef.c14 * $signed({1'b0, item.stiffness});
			prod23_s1 <= coef.c23 * $signed({1'b0, item.stiffness});
		end
	end

	// stage 2: round and saturate the two gains
	assign r14 = rnd_sat(PROD_W'(prod14_s1));
	assign r23 = rnd_sat(PROD_W'(prod23_s1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			st_s2.q   <= item_s1.position;
			st_s2.p   <= item_s1.momentum;
			st_s2.g14 <= r14[DATA_W-1:0];
			st_s2.g23 <= r23[DATA_W-1:0];
			st_s2.ov  <= r14[DATA_W] | r23[DATA_W];
		end
	end

	assign out_valid = valid_s2;
	assign out_st    = st_s2;

endmodule

[src/sfo_kick.sv]
module sfo_kick import sfo_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  state_t                   in_st,
	input  logic signed [DATA_W-1:0] gain,
	output logic                     out_valid,
	input  logic                     out_ready,
	output state_t                   out_st
);

	logic                     valid_s1;
	state_t                   st_s1;
	logic signed [PROD_W-1:0] prod_s1;
	logic                     valid_s2;
	state_t                   st_s2;
	logic                     ready_s1;
	logic                     ready_s2;
	logic [DATA_W:0]          f;
	logic [DATA_W:0]          p_new;
	state_t                   st_next;

	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	// stage 1: force product gain * q
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			st_s1   <= in_st;
			prod_s1 <= gain * in_st.q;
		end
	end

	// stage 2: round the force and take it off the momentum
	assign f     = rnd_sat(prod_s1);
	assign p_new = sat_sum(st_s1.p, f[DATA_W-1:0], 1'b1);

	// updated state for the second register
	always_comb begin
		st_next    = st_s1;
		st_next.p  = p_new[DATA_W-1:0];
		st_next.ov = st_s1.ov | f[DATA_W] | p_new[DATA_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			st_s2 <= st_next;
		end
	end

	assign out_valid = valid_s2;
	assign out_st    = st_s2;

endmodule

[src/sfo_drift.sv]
module sfo_drift import sfo_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  state_t                 in_st,
	input  logic signed [CD_W-1:0] cd,
	output logic                   out_valid,
	input  logic                   out_ready,
	output state_t                 out_st
);

	logic                    valid_s1;
	state_t                  st_s1;
	logic signed [MUL_W-1:0] prod_s1;
	logic                    valid_s2;
	state_t                  st_s2;
	logic                    ready_s1;
	logic                    ready_s2;
	logic [DATA_W:0]         h;
	logic [DATA_W:0]         q_new;
	state_t                  st_next;

	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	// stage 1: displacement product cd * p
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			st_s1   <= in_st;
			prod_s1 <= cd * in_st.p;
		end
	end

	// stage 2: round the displacement and add it to the position
	assign h     = rnd_sat(PROD_W'(prod_s1));
	assign q_new = sat_sum(st_s1.q, h[DATA_W-1:0], 1'b0);

	// updated state for the second register
	always_comb begin
		st_next    = st_s1;
		st_next.q  = q_new[DATA_W-1:0];
		st_next.ov = st_s1.ov | h[DATA_W] | q_new[DATA_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			st_s2 <= st_next;
		end
	end

	assign out_valid = valid_s2;
	assign out_st    = st_s2;

endmodule

[src/sfo_checker.sv]
module sfo_checker import sfo_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	input logic            item_stall,
	input logic            result_valid,
	input logic            result_stall,
	input result_t         result,
	input logic            cfg_valid,
	input logic            cfg_ready
);

	// a stalled result stays put
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// an empty output stage means every stage can move, so the input is open
	a_empty_open: assert property (@(posedge clk)
		!result_valid |-> !item_stall)
		else $error("input stalled with empty output");

	// reset drains the pipeline
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !result_valid)
		else $error("result valid during reset");

	// step size writes are never held off
	a_cfg_open: assert property (@(posedge clk)
		cfg_valid |-> cfg_ready)
		else $error("configuration write held off");

endmodule

bind symplectic_fourth_order_oscillator_step sfo_checker u_sfo_checker (.*);

[tb/tb_symplectic_fourth_order_oscillator_step.sv]
module tb_symplectic_fourth_order_oscillator_step;
	import sfo_pkg::*;

	localparam longint DATA_MAX = (64'sd1 <<< (DATA_W - 1)) - 1;
	localparam longint DATA_MIN = -DATA_MAX - 1;
	localparam logic [DATA_W-1:0] Q_MAX = SAT_MAX;
	localparam logic [DATA_W-1:0] Q_MIN = SAT_MIN;
	localparam logic [K_W-1:0] K_MAX = {K_W{1'b1}};
	localparam logic [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;
	localparam logic [DT_W-1:0] DT_FULL = {DT_W{1'b1}};
	localparam int DRAIN_CYCLES = 24;

	// rounded or saturated value with its saturation flag
	typedef struct packed {
		logic                ov;
		logic signed [63:0]  v;
	} rounded_t;

	logic            clk;
	logic            arst_n;
	logic            item_valid;
	logic            item_stall;
	item_t           item;
	logic            result_valid;
	logic            result_stall;
	result_t         result;
	logic            cfg_valid;
	logic            cfg_ready;
	logic [DT_W-1:0] cfg_time_step;

	// step size the block holds, tracked on every register write
	logic [DT_W-1:0] step_size;
	result_t         pending_results[$];
	int              fail_count = 0;
	bit              idle_on = 1'b0;
	int              hold_results = 0;
	int              stall_cnt = 0;

	symplectic_fourth_order_oscillator_step dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_time_step(cfg_time_step)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// round(a*b / 2^sh) ties away from zero, saturated to a signed w-bit range
	function automatic rounded_t mul_round(longint a, longint b, int unsigned sh,
			int unsigned w);
		rounded_t     r;
		logic [63:0]  ua;
		logic [63:0]  ub;
		logic [127:0] mag;
		logic [127:0] lim;
		bit           neg;
		neg = (a < 0) != (b < 0);
		ua = a;
		ub = b;
		if (a < 0) ua = -ua;
		if (b < 0) ub = -ub;
		mag = {64'd0, ua} * {64'd0, ub};
		mag = (mag + (128'd1 << (sh - 1))) >> sh;
		lim = 128'd1 << (w - 1);
		r.ov = 1'b0;
		if (neg) begin
			if (mag > lim) begin
				r.ov = 1'b1;
				mag = lim;
			end
			r.v = -$signed(mag[63:0]);
		end else begin
			if (mag > lim - 1) begin
				r.ov = 1'b1;
				mag = lim - 1;
			end
			r.v = $signed(mag[63:0]);
		end
		return r;
	endfunction

	function automatic rounded_t clamp_data(longint s);
		rounded_t r;
		r.ov = 1'b1;
		if (s > DATA_MAX) r.v = DATA_MAX;
		else if (s < DATA_MIN) r.v = DATA_MIN;
		else begin
			r.ov = 1'b0;
			r.v = s;
		end
		return r;
	endfunction

	// p -= round(round(cd*k)*q)
	function automatic rounded_t kick(longint p, longint q, longint k, longint cd);
		rounded_t g;
		rounded_t f;
		rounded_t s;
		g = mul_round(cd, k, FRAC_BITS, DATA_W);
		f = mul_round(g.v, q, FRAC_BITS, DATA_W);
		s = clamp_data(p - f.v);
		s.ov = s.ov | g.ov | f.ov;
		return s;
	endfunction

	// q += round(cd*p)
	function automatic rounded_t drift(longint q, longint p, longint cd);
		rounded_t h;
		rounded_t s;
		h = mul_round(cd, p, FRAC_BITS, DATA_W);
		s = clamp_data(q + h.v);
		s.ov = s.ov | h.ov;
		return s;
	endfunction

	// one full fourth-order step of one oscillator
	function automatic result_t yoshida_step(item_t it, logic [DT_W-1:0] dt);
		longint   q;
		longint   p;
		longint   k;
		longint   c14;
		longint   c23;
		longint   d13;
		longint   d2;
		logic     ov;
		rounded_t r;
		result_t  res;
		q = $signed(it.position);
		p = $signed(it.momentum);
		k = longint'({1'b0, it.stiffness});
		r = mul_round(COEF_C14, longint'({1'b0, dt}), FRAC_BITS, 64);
		c14 = r.v;
		r = mul_round(COEF_C23, longint'({1'b0, dt}), FRAC_BITS, 64);
		c23 = r.v;
		r = mul_round(COEF_D13, longint'({1'b0, dt}), FRAC_BITS, 64);
		d13 = r.v;
		r = mul_round(COEF_D2, longint'({1'b0, dt}), FRAC_BITS, 64);
		d2 = r.v;
		ov = 1'b0;
		r = kick(p, q, k, c14);  p = r.v; ov |= r.ov;
		r = drift(q, p, d13);    q = r.v; ov |= r.ov;
		r = kick(p, q, k, c23);  p = r.v; ov |= r.ov;
		r = drift(q, p, d2);     q = r.v; ov |= r.ov;
		r = kick(p, q, k, c23);  p = r.v; ov |= r.ov;
		r = drift(q, p, d13);    q = r.v; ov |= r.ov;
		r = kick(p, q, k, c14);  p = r.v; ov |= r.ov;
		res.position_next = q[DATA_W-1:0];
		res.momentum_next = p[DATA_W-1:0];
		res.overflow = ov;
		return res;
	endfunction

	// mostly no gap, some short, a few long
	function automatic int pick_gap();
		int r;
		if (!idle_on) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [31:0] corner_word();
		case ($urandom_range(0, 5))
			0: return 32'h0;
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'hFFFF_FFFF;
			4: return 32'h1;
			default: return $urandom;
		endcase
	endfunction

	// send one oscillator request and record its expected result
	task automatic send_item(logic [DATA_W-1:0] q, logic [DATA_W-1:0] p, logic [K_W-1:0] k);
		item_t it;
		int    gap;
		it.position = q;
		it.momentum = p;
		it.stiffness = k;
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		pending_results.push_back(yoshida_step(it, step_size));
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// mix of physical values, raw bit patterns and corners
	task automatic send_random_item();
		logic [31:0] q;
		logic [31:0] p;
		logic [31:0] k;
		int          r;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			q = int'($urandom_range(0, 32'h1000_0000)) - 32'sh0800_0000;
			p = int'($urandom_range(0, 32'h1000_0000)) - 32'sh0800_0000;
			k = $urandom_range(0, 32'h1000_0000);
		end else if (r < 80) begin
			q = $urandom;
			p = $urandom;
			k = $urandom;
		end else begin
			q = corner_word();
			p = corner_word();
			k = corner_word();
		end
		send_item(q, p, k[K_W-1:0]);
	endtask

	// stop offering and wait until every expected result has come back
	task automatic wait_drained();
		item_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_time_step(logic [DT_W-1:0] dt);
		cfg_time_step <= dt;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		step_size = dt;
	endtask

	// step size from reset, field extremes and saturation
	task automatic test_reset_step();
		idle_on = 1'b0;
		send_item(0, 0, 0);
		send_item(ONE, 0, ONE[K_W-1:0]);
		send_item(0, ONE, ONE[K_W-1:0]);
		send_item(-ONE, DATA_W'(3 << (FRAC_BITS - 1)), K_W'(4 << FRAC_BITS));
		send_item(Q_MAX, Q_MAX, K_MAX);
		send_item(Q_MIN, Q_MIN, K_MAX);
		send_item(Q_MIN, Q_MAX, 0);
		send_item(Q_MAX, Q_MIN, 1);
		send_item('1, 1, K_MAX);
		send_item(1, '1, 1);
		wait_drained();
	endtask

	// zero step leaves the oscillator unchanged
	task automatic test_zero_step();
		write_time_step('0);
		send_item(Q_MAX, Q_MIN, K_MAX);
		send_item(ONE, ONE, ONE[K_W-1:0]);
		send_item(Q_MIN, Q_MAX, K_MAX);
		wait_drained();
	endtask

	// largest step drives most stages into saturation
	task automatic test_max_step();
		write_time_step(DT_FULL);
		send_item(ONE, 0, ONE[K_W-1:0]);
		send_item(Q_MAX, Q_MAX, K_MAX);
		send_item(Q_MIN, Q_MAX, K_MAX);
		send_item(DATA_W'(-(1 << 20)), DATA_W'(1 << 22), K_W'(1 << 26));
		send_item(0, Q_MIN, 0);
		wait_drained();
	endtask

	// receiver holds off long enough that the pipeline backs up into item_stall
	task automatic test_backpressure();
		write_time_step(DT_RESET);
		idle_on = 1'b0;
		hold_results = 300;
		repeat (100) send_random_item();
		wait_drained();
	endtask

	// random oscillators across a series of step sizes
	task automatic test_random_sweep();
		logic [DT_W-1:0] dt;
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: dt = 1;
				1: dt = DT_FULL;
				2: dt = DT_RESET;
				3: dt = 0;
				default: dt = $urandom_range(0, 1) ? DT_W'($urandom_range(0, DT_FULL))
					: DT_W'($urandom_range(1, 24'h7FFFF));
			endcase
			write_time_step(dt);
			idle_on = (ph % 3) != 2;
			repeat (128) send_random_item();
			wait_drained();
		end
	endtask

	// receiver side: random stalls plus the long hold-off when asked
	initial begin
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_results > 0) begin
				result_stall <= 1'b1;
				hold_results--;
			end else if (stall_cnt > 0) begin
				result_stall <= 1'b1;
				stall_cnt--;
			end else begin
				stall_cnt = pick_gap();
				if (stall_cnt > 0) begin
					result_stall <= 1'b1;
					stall_cnt--;
				end else begin
					result_stall <= 1'b0;
				end
			end
		end
	end

	// compare each accepted result with the oldest expected one
	always @(posedge clk) begin
		result_t exp_res;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result pos %0d mom %0d ov %0b", $time,
					result.position_next, result.momentum_next, result.overflow);
				fail_count++;
			end else begin
				exp_res = pending_results.pop_front();
				if (result.position_next !== exp_res.position_next) begin
					$display("%0t: position_next expected %0d got %0d", $time,
						exp_res.position_next, result.position_next);
					fail_count++;
				end
				if (result.momentum_next !== exp_res.momentum_next) begin
					$display("%0t: momentum_next expected %0d got %0d", $time,
						exp_res.momentum_next, result.momentum_next);
					fail_count++;
				end
				if (result.overflow !== exp_res.overflow) begin
					$display("%0t: overflow expected %0b got %0b", $time,
						exp_res.overflow, result.overflow);
					fail_count++;
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("tb_symplectic_fourth_order_oscillator_step: FAIL");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		cfg_valid <= 1'b0;
		cfg_time_step <= '0;
		step_size = DT_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_step();
		test_zero_step();
		test_max_step();
		test_backpressure();
		test_random_sweep();
		wait_drained();
		if (fail_count == 0) begin
			$display("tb_symplectic_fourth_order_oscillator_step: PASS");
		end else begin
			$display("tb_symplectic_fourth_order_oscillator_step: FAIL");
		end
		$finish;
	end

endmodule

[filelist.f]
src/sfo_pkg.sv
src/sfo_cfg.sv
src/sfo_gain.sv
src/sfo_kick.sv
src/sfo_drift.sv
src/symplectic_fourth_order_oscillator_step.sv
src/sfo_checker.sv
tb/tb_symplectic_fourth_order_oscillator_step.sv
